// File: rtl/klx_pkg.sv
// Package for the keyword lexer stream: token kinds, pending classes, the token record
// and the character classification and keyword lookup functions.
// Used by keyword_lexer_stream and klx_checker; it depends on nothing else.
package klx_pkg;

    localparam int MAX_TOKENS_DEF = 1024;
    localparam int POS_BITS_DEF   = 16;
    localparam int OUT_POS_W      = 16;
    localparam int WORD_DEPTH     = 6;

    typedef enum logic [3:0] {
        KIND_END      = 4'd0,
        KIND_NUMBER   = 4'd1,
        KIND_IDENT    = 4'd2,
        KIND_DECLVAR  = 4'd3,
        KIND_DECLFN   = 4'd4,
        KIND_RETURN   = 4'd5,
        KIND_IF       = 4'd6,
        KIND_ELSE     = 4'd7,
        KIND_FOR      = 4'd8,
        KIND_WHILE    = 4'd9,
        KIND_OP       = 4'd10,
        KIND_COMPOUND = 4'd11,
        KIND_ARROW    = 4'd12,
        KIND_SEMI     = 4'd13,
        KIND_OTHER    = 4'd14
    } kind_t;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_NUMBER = 2'd1,
        CLS_WORD   = 2'd2,
        CLS_CHAR   = 2'd3
    } cls_t;

    typedef logic [WORD_DEPTH-1:0][7:0] word_t;

    typedef struct packed {
        kind_t                kind;
        logic [OUT_POS_W-1:0] start_pos;
        logic [OUT_POS_W-1:0] end_pos;
        logic [7:0]           lead_char;
        logic                 last;
    } token_t;

    // Keywords are stored with their first character in the lowest byte and zero padding.
    localparam word_t KW_CONST  = {8'h00, "tsnoc"};
    localparam word_t KW_LET    = {24'h0, "tel"};
    localparam word_t KW_FN     = {32'h0, "nf"};
    localparam word_t KW_RETURN = "nruter";
    localparam word_t KW_IF     = {32'h0, "fi"};
    localparam word_t KW_ELSE   = {16'h0, "esle"};
    localparam word_t KW_FOR    = {24'h0, "rof"};
    localparam word_t KW_WHILE  = {8'h00, "elihw"};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd13);
    endfunction

    function automatic kind_t char_kind(input logic [7:0] c);
        kind_t k;
        if (is_op(c)) begin
            k = KIND_OP;
        end else if (c == ";") begin
            k = KIND_SEMI;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

    // Characters past the word length are zero, so a full compare plus a length check suffices.
    function automatic kind_t word_kind(input word_t chars, input logic [2:0] len);
        kind_t k;
        k = KIND_IDENT;
        if (len == 3'd5 && chars == KW_CONST) begin
            k = KIND_DECLVAR;
        end else if (len == 3'd3 && chars == KW_LET) begin
            k = KIND_DECLVAR;
        end else if (len == 3'd2 && chars == KW_FN) begin
            k = KIND_DECLFN;
        end else if (len == 3'd6 && chars == KW_RETURN) begin
            k = KIND_RETURN;
        end else if (len == 3'd2 && chars == KW_IF) begin
            k = KIND_IF;
        end else if (len == 3'd4 && chars == KW_ELSE) begin
            k = KIND_ELSE;
        end else if (len == 3'd3 && chars == KW_FOR) begin
            k = KIND_FOR;
        end else if (len == 3'd5 && chars == KW_WHILE) begin
            k = KIND_WHILE;
        end
        return k;
    endfunction

endpackage

// File: rtl/keyword_lexer_stream.sv
// Keyword lexer stream top level: byte classification, pending token state and a
// four-entry token queue toward the result channel.
// Depends on klx_pkg for token kinds, the token record and the character functions.
//
// Usage: text bytes enter on s_valid/s_ready/s_text_byte, one byte per transaction, a zero
// byte ending the text. Tokens leave on m_valid/m_ready with kind, start and end offsets,
// the lead character and a flag marking the end token that closes a text.
// Throughput is one byte per cycle while s_ready is high. Each byte updates the lexer state in
// the cycle it is accepted and pushes zero, one or two tokens into the queue; a token is
// presented once the tokens queued ahead of it have been taken. A token is completed by the
// byte after it, so a word or number enters the queue when its delimiter is accepted.
// s_ready is high while the queue has room for two tokens. When the receiver stalls the
// queue fills and s_ready drops; it rises again as soon as two slots are free, so a
// stall of any length loses nothing and bytes flow at one per cycle once tokens are taken.
// A synchronous active-low reset empties the queue and returns the lexer to the start of a
// text at offset zero.
module keyword_lexer_stream #(
    parameter int MAX_TOKENS = klx_pkg::MAX_TOKENS_DEF,
    parameter int POS_BITS   = klx_pkg::POS_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_text_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [3:0]                   m_token_kind,
    output logic [klx_pkg::OUT_POS_W-1:0] m_start_pos,
    output logic [klx_pkg::OUT_POS_W-1:0] m_end_pos,
    output logic [7:0]                   m_lead_char,
    output logic                         m_last_of_text
);
    import klx_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOKENS);
    localparam int EXT_W = POS_BITS + OUT_POS_W;
    localparam logic [CNT_W:0] CAP_COUNT = (CNT_W + 1)'(MAX_TOKENS - 1);
    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam int Q_DEPTH = 4;
    localparam int QP_W = $clog2(Q_DEPTH);

    logic [POS_BITS-1:0] position_reg, position_next;
    cls_t                pcls_reg, pcls_next;
    logic [POS_BITS-1:0] pstart_reg, pstart_next;
    word_t               chars_reg, chars_next;
    logic [2:0]          wlen_reg, wlen_next;
    logic [7:0]          pop_reg, pop_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                capped_reg, capped_next;

    token_t              queue_reg [Q_DEPTH];
    logic [QP_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QP_W:0]       fill_reg, fill_next;

    logic                accept, pop_out;
    logic [7:0]          b;
    logic [POS_BITS-1:0] inc_p, inc_ps;
    logic                fl_valid, absorbed, restart, adv, cap_hit;
    kind_t               fl_kind;
    logic [POS_BITS-1:0] fl_e;
    logic [7:0]          fl_lead;
    logic [CNT_W:0]      cnt_inc;
    token_t              tok [2];
    logic [1:0]          n_tok;

    function automatic logic [OUT_POS_W-1:0] to_out(input logic [POS_BITS-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[OUT_POS_W-1:0];
    endfunction

    assign b       = s_text_byte;
    assign s_ready = (fill_reg <= (QP_W + 1)'(Q_DEPTH - 2));
    assign accept  = s_valid && s_ready;
    assign m_valid = (fill_reg != '0);
    assign pop_out = m_valid && m_ready;
    assign inc_p   = (position_reg == POS_MAX) ? position_reg : position_reg + 1'b1;
    assign inc_ps  = (pstart_reg == POS_MAX) ? pstart_reg : pstart_reg + 1'b1;
    assign cnt_inc = {1'b0, count_reg} + 1'b1;

    always_comb begin
        position_next = position_reg;
        pcls_next     = pcls_reg;
        pstart_next   = pstart_reg;
        chars_next    = chars_reg;
        wlen_next     = wlen_reg;
        pop_next      = pop_reg;
        count_next    = count_reg;
        capped_next   = capped_reg;
        tok[0]        = '0;
        tok[1]        = '0;
        n_tok         = 2'd0;
        fl_valid      = 1'b0;
        fl_kind       = KIND_END;
        fl_e          = position_reg;
        fl_lead       = 8'd0;
        absorbed      = 1'b0;
        restart       = 1'b0;
        adv           = 1'b0;
        cap_hit       = 1'b0;
        if (capped_reg) begin
            restart = (b == 8'd0);
        end else begin
            unique case (pcls_reg)
                CLS_CHAR: begin
                    fl_valid = 1'b1;
                    fl_lead  = pop_reg;
                    if (is_op(pop_reg) && b == "=") begin
                        fl_kind  = KIND_COMPOUND;
                        fl_e     = inc_p;
                        absorbed = 1'b1;
                        adv      = 1'b1;
                    end else if (pop_reg == "=" && b == ">") begin
                        fl_kind  = KIND_ARROW;
                        fl_e     = inc_p;
                        absorbed = 1'b1;
                        adv      = 1'b1;
                    end else begin
                        fl_kind = char_kind(pop_reg);
                        fl_e    = inc_ps;
                    end
                end
                CLS_NUMBER: begin
                    if (is_digit(b)) begin
                        absorbed = 1'b1;
                        adv      = 1'b1;
                    end else begin
                        fl_valid = 1'b1;
                        fl_kind  = KIND_NUMBER;
                    end
                end
                CLS_WORD: begin
                    if (is_alpha(b) || is_digit(b) || b == "_") begin
                        absorbed = 1'b1;
                        adv      = 1'b1;
                        if (wlen_reg < 3'd6) begin
                            chars_next[wlen_reg] = b;
                        end
                        if (wlen_reg < 3'd7) begin
                            wlen_next = wlen_reg + 3'd1;
                        end
                    end else begin
                        fl_valid = 1'b1;
                        fl_kind  = word_kind(chars_reg, wlen_reg);
                    end
                end
                default: begin
                end
            endcase

            if (fl_valid) begin
                tok[0]     = '{fl_kind, to_out(pstart_reg), to_out(fl_e), fl_lead, 1'b0};
                n_tok      = 2'd1;
                count_next = cnt_inc[CNT_W-1:0];
                pcls_next  = CLS_NONE;
                cap_hit    = (cnt_inc >= CAP_COUNT);
            end

            if (cap_hit) begin
                tok[1]      = '{KIND_END, to_out(fl_e), to_out(fl_e), 8'd0, 1'b1};
                n_tok       = 2'd2;
                capped_next = 1'b1;
            end else if (!absorbed) begin
                if (b == 8'd0) begin
                    tok[n_tok[0]] = '{KIND_END, to_out(position_reg), to_out(position_reg),
                                      8'd0, 1'b1};
                    n_tok         = n_tok + 2'd1;
                    restart       = 1'b1;
                end else if (is_space(b)) begin
                    adv = 1'b1;
                end else begin
                    pstart_next = position_reg;
                    adv         = 1'b1;
                    if (is_digit(b)) begin
                        pcls_next = CLS_NUMBER;
                    end else if (is_alpha(b)) begin
                        pcls_next     = CLS_WORD;
                        chars_next    = '0;
                        chars_next[0] = b;
                        wlen_next     = 3'd1;
                    end else begin
                        pcls_next = CLS_CHAR;
                        pop_next  = b;
                    end
                end
            end
        end

        if (adv) begin
            position_next = inc_p;
        end
        if (restart) begin
            position_next = '0;
            pcls_next     = CLS_NONE;
            pstart_next   = '0;
            chars_next    = '0;
            wlen_next     = 3'd0;
            pop_next      = 8'd0;
            count_next    = '0;
            capped_next   = 1'b0;
        end
    end

    always_comb begin
        fill_next = fill_reg + (accept ? (QP_W + 1)'(n_tok) : '0) - (QP_W + 1)'(pop_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            pcls_reg     <= CLS_NONE;
            pstart_reg   <= '0;
            chars_reg    <= '0;
            wlen_reg     <= 3'd0;
            pop_reg      <= 8'd0;
            count_reg    <= '0;
            capped_reg   <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fill_reg     <= '0;
        end else begin
            if (accept) begin
                position_reg <= position_next;
                pcls_reg     <= pcls_next;
                pstart_reg   <= pstart_next;
                chars_reg    <= chars_next;
                wlen_reg     <= wlen_next;
                pop_reg      <= pop_next;
                count_reg    <= count_next;
                capped_reg   <= capped_next;
                wr_ptr_reg   <= wr_ptr_reg + QP_W'(n_tok);
            end
            if (pop_out) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && n_tok != 2'd0) begin
            queue_reg[wr_ptr_reg] <= tok[0];
        end
        if (accept && n_tok == 2'd2) begin
            queue_reg[wr_ptr_reg + 1'b1] <= tok[1];
        end
    end

    assign m_token_kind   = queue_reg[rd_ptr_reg].kind;
    assign m_start_pos    = queue_reg[rd_ptr_reg].start_pos;
    assign m_end_pos      = queue_reg[rd_ptr_reg].end_pos;
    assign m_lead_char    = queue_reg[rd_ptr_reg].lead_char;
    assign m_last_of_text = queue_reg[rd_ptr_reg].last;

endmodule

// File: rtl/klx_checker.sv
// Port-level checks for keyword_lexer_stream, attached to it by the bind statement below.
// Depends on klx_pkg for the token kind codes.
module klx_sva (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [3:0]                    m_token_kind,
    input logic [klx_pkg::OUT_POS_W-1:0] m_start_pos,
    input logic [klx_pkg::OUT_POS_W-1:0] m_end_pos,
    input logic [7:0]                    m_lead_char,
    input logic                          m_last_of_text
);
    import klx_pkg::*;

    // A stalled result transaction must stay presented.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    // After reset no result is presented.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result presented right after reset");

    // The end flag appears only on end tokens, and every end token carries it.
    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_of_text == (m_token_kind == KIND_END)))
        else $error("end flag and end kind disagree");

    // End tokens are empty spans.
    a_end_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == KIND_END |-> m_start_pos == m_end_pos)
        else $error("end token with nonempty span");

    // Numbers and words carry no lead character.
    a_word_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind >= KIND_NUMBER && m_token_kind <= KIND_WHILE
        |-> m_lead_char == 8'd0)
        else $error("word or number token with a lead character");

endmodule

bind keyword_lexer_stream klx_sva u_klx_sva (.*);

// File: sim/klx_checker.sv
// Token checker for the keyword lexer stream: watches both channels, predicts the tokens
// of every accepted text byte and compares them field by field with the result channel.
// Depends on klx_pkg for the token kinds, pending classes, the token record and the limits.
module klx_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_text_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [3:0]                    m_token_kind,
    input  logic [klx_pkg::OUT_POS_W-1:0] m_start_pos,
    input  logic [klx_pkg::OUT_POS_W-1:0] m_end_pos,
    input  logic [7:0]                    m_lead_char,
    input  logic                          m_last_of_text,
    output int                            mismatches,
    output int                            tokens_due_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    import klx_pkg::*;

    localparam logic [31:0] POS_MAX  = 32'((64'd1 << POS_BITS_DEF) - 64'd1);
    localparam logic [47:0] W_CONST  = "const";
    localparam logic [47:0] W_LET    = "let";
    localparam logic [47:0] W_FN     = "fn";
    localparam logic [47:0] W_RETURN = "return";
    localparam logic [47:0] W_IF     = "if";
    localparam logic [47:0] W_ELSE   = "else";
    localparam logic [47:0] W_FOR    = "for";
    localparam logic [47:0] W_WHILE  = "while";

    logic [31:0] pos;
    logic [31:0] tok_start;
    cls_t        pend_cls;
    logic [7:0]  wchars [WORD_DEPTH];
    logic [2:0]  wlen;
    logic [7:0]  pend_op;
    logic [10:0] n_emitted;
    bit          capped;
    token_t      tokens_due [$];
    token_t      due;

    function automatic logic [31:0] step_pos(input logic [31:0] p);
        return (p >= POS_MAX) ? POS_MAX : p + 32'd1;
    endfunction

    function automatic bit digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alpha_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit op_ch(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "=";
    endfunction

    function automatic void restart_text();
        pos       = '0;
        tok_start = '0;
        pend_cls  = CLS_NONE;
        wchars    = '{default: '0};
        wlen      = '0;
        pend_op   = '0;
        n_emitted = '0;
        capped    = 1'b0;
    endfunction

    function automatic void push_tok(input kind_t k, input logic [31:0] s, input logic [31:0] e,
                                     input logic [7:0] lead, input logic last);
        token_t t;
        t.kind      = k;
        t.start_pos = s[OUT_POS_W-1:0];
        t.end_pos   = e[OUT_POS_W-1:0];
        t.lead_char = lead;
        t.last      = last;
        tokens_due.push_back(t);
    endfunction

    // Emits a finished token; once the token limit is reached an end token closes the text.
    function automatic bit close_token(input kind_t k, input logic [31:0] s,
                                       input logic [31:0] e, input logic [7:0] lead);
        push_tok(k, s, e, lead, 1'b0);
        n_emitted = n_emitted + 11'd1;
        if (n_emitted >= 11'(MAX_TOKENS_DEF - 1)) begin
            push_tok(KIND_END, e, e, 8'd0, 1'b1);
            capped = 1'b1;
        end
        pend_cls = CLS_NONE;
        return capped;
    endfunction

    function automatic void lex_byte(input logic [7:0] b);
        logic [31:0] p;
        logic [7:0]  c;
        logic [47:0] w;
        kind_t       wk;
        int          j;
        p = pos;
        if (capped) begin
            if (b == 8'd0) begin
                restart_text();
            end
            return;
        end
        if (pend_cls == CLS_CHAR) begin
            c = pend_op;
            if ((op_ch(c) && b == "=") || (c == "=" && b == ">")) begin
                void'(close_token((b == "=") ? KIND_COMPOUND : KIND_ARROW, tok_start,
                                  step_pos(p), c));
                if (!capped) begin
                    pos = step_pos(p);
                end
                return;
            end
            if (close_token(op_ch(c) ? KIND_OP : ((c == ";") ? KIND_SEMI : KIND_OTHER),
                            tok_start, step_pos(tok_start), c)) begin
                return;
            end
        end else if (pend_cls == CLS_NUMBER) begin
            if (digit_ch(b)) begin
                pos = step_pos(p);
                return;
            end
            if (close_token(KIND_NUMBER, tok_start, p, 8'd0)) begin
                return;
            end
        end else if (pend_cls == CLS_WORD) begin
            if (alpha_ch(b) || digit_ch(b) || b == "_") begin
                if (wlen < 3'd6) begin
                    wchars[wlen] = b;
                end
                if (wlen < 3'd7) begin
                    wlen = wlen + 3'd1;
                end
                pos = step_pos(p);
                return;
            end
            // Words longer than six characters can never be keywords.
            w  = '0;
            wk = KIND_IDENT;
            if (wlen <= 3'd6) begin
                for (j = 0; j < int'(wlen); j++) begin
                    w = {w[39:0], wchars[j]};
                end
                case (w)
                    W_CONST, W_LET: wk = KIND_DECLVAR;
                    W_FN:           wk = KIND_DECLFN;
                    W_RETURN:       wk = KIND_RETURN;
                    W_IF:           wk = KIND_IF;
                    W_ELSE:         wk = KIND_ELSE;
                    W_FOR:          wk = KIND_FOR;
                    W_WHILE:        wk = KIND_WHILE;
                    default:        wk = KIND_IDENT;
                endcase
            end
            if (close_token(wk, tok_start, p, 8'd0)) begin
                return;
            end
        end
        if (b == 8'd0) begin
            push_tok(KIND_END, p, p, 8'd0, 1'b1);
            restart_text();
            return;
        end
        if (b == 8'd32 || b == 8'd9 || b == 8'd10 || b == 8'd13) begin
            pos = step_pos(p);
            return;
        end
        tok_start = p;
        if (digit_ch(b)) begin
            pend_cls = CLS_NUMBER;
        end else if (alpha_ch(b)) begin
            pend_cls  = CLS_WORD;
            wchars    = '{default: '0};
            wchars[0] = b;
            wlen      = 3'd1;
        end else begin
            pend_cls = CLS_CHAR;
            pend_op  = b;
        end
        pos = step_pos(p);
    endfunction

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_text();
            tokens_due.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: token expected none, actual kind %0d start %0d",
                             $time, m_token_kind, m_start_pos);
                end else begin
                    due = tokens_due.pop_front();
                    if (m_token_kind !== due.kind) begin
                        note_mismatch("token_kind", due.kind, m_token_kind);
                    end
                    if (m_start_pos !== due.start_pos) begin
                        note_mismatch("start_pos", due.start_pos, m_start_pos);
                    end
                    if (m_end_pos !== due.end_pos) begin
                        note_mismatch("end_pos", due.end_pos, m_end_pos);
                    end
                    if (m_lead_char !== due.lead_char) begin
                        note_mismatch("lead_char", due.lead_char, m_lead_char);
                    end
                    if (m_last_of_text !== due.last) begin
                        note_mismatch("last_of_text", due.last, m_last_of_text);
                    end
                end
            end
            if (s_valid && s_ready) begin
                lex_byte(s_text_byte);
            end
        end
        tokens_due_cnt = tokens_due.size();
    end

endmodule

// File: sim/tb.sv
// Top of the keyword lexer stream testbench: clock, reset, text stimulus and random
// receiver stalls, with the verdict taken from klx_checker.
// Depends on klx_pkg, keyword_lexer_stream and klx_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import klx_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          RANDOM_BYTES = 2000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_text_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [3:0]           m_token_kind;
    logic [OUT_POS_W-1:0] m_start_pos;
    logic [OUT_POS_W-1:0] m_end_pos;
    logic [7:0]           m_lead_char;
    logic                 m_last_of_text;
    int                   mismatches;
    int                   tokens_due_cnt;
    int unsigned          cycles = 0;
    bit                   calm;
    bit                   hold_req;
    int                   sent;
    logic [7:0]           text_q [$];
    string                keywords [8] = '{"const", "let", "fn", "return",
                                            "if", "else", "for", "while"};

    keyword_lexer_stream uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_start_pos    (m_start_pos),
        .m_end_pos      (m_end_pos),
        .m_lead_char    (m_lead_char),
        .m_last_of_text (m_last_of_text)
    );

    klx_checker lex_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_start_pos    (m_start_pos),
        .m_end_pos      (m_end_pos),
        .m_lead_char    (m_lead_char),
        .m_last_of_text (m_last_of_text),
        .mismatches     (mismatches),
        .tokens_due_cnt (tokens_due_cnt)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // The receiver stalls at random, and once holds off long enough to back up the input.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    function automatic logic [7:0] letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 11);
        if (r < 8) begin
            return letter();
        end else if (r < 11) begin
            return 8'("0" + $urandom_range(0, 9));
        end
        return "_";
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endfunction

    function automatic void add_gap();
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5: text_q.push_back(" ");
            6:       text_q.push_back("\t");
            7:       text_q.push_back("\n");
            8:       text_q.push_back(8'd13);
            default: begin
                add_str("  ");
                text_q.push_back(8'd13);
                text_q.push_back(8'd10);
            end
        endcase
    endfunction

    function automatic void add_lexeme();
        string ops;
        string odd;
        string mix;
        ops = "+-*/=";
        odd = "\"'_(){},.!#<>";
        mix = "+-*/=>;";
        case ($urandom_range(0, 11))
            0: add_str(keywords[$urandom_range(0, 7)]);
            1: begin
                text_q.push_back(letter());
                repeat ($urandom_range(0, 5)) text_q.push_back(word_char());
            end
            2: begin
                // Near misses of keywords: one character more or one less.
                add_str(keywords[$urandom_range(0, 7)]);
                if ($urandom_range(0, 1) == 1) begin
                    text_q.push_back(word_char());
                end else begin
                    void'(text_q.pop_back());
                end
            end
            3: repeat ($urandom_range(1, 6)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
            4: text_q.push_back(ops[$urandom_range(0, 4)]);
            5: begin
                text_q.push_back(ops[$urandom_range(0, 4)]);
                text_q.push_back("=");
            end
            6: add_str("=>");
            7: text_q.push_back(";");
            8: begin
                if ($urandom_range(0, 1) == 1) begin
                    text_q.push_back(odd[$urandom_range(0, odd.len() - 1)]);
                end else begin
                    text_q.push_back(8'($urandom_range(128, 255)));
                end
            end
            9: begin
                text_q.push_back(letter());
                repeat ($urandom_range(6, 11)) text_q.push_back(word_char());
            end
            10: repeat ($urandom_range(2, 4)) text_q.push_back(mix[$urandom_range(0, 6)]);
            default: text_q.push_back(8'($urandom_range(1, 255)));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 31) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_byte(text_q[i]);
        end
        sent += text_q.size();
        text_q.delete();
    endtask

    initial begin
        bit cap_done;
        bit hold_done;
        int r;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_text_byte = 8'd0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        sent        = 0;
        cap_done    = 1'b0;
        hold_done   = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_str("let fn+=9=>_");
        text_q.push_back(8'hff);
        add_str(";\"");
        text_q.push_back(8'd0);
        add_str("ab1cdefg/x-");
        text_q.push_back(8'd0);
        text_q.push_back(8'd0);
        send_text();

        while (sent < RANDOM_BYTES) begin
            calm = 1'b0;
            r    = $urandom_range(0, 99);
            if (!hold_done && sent > 250) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                repeat (60) begin
                    add_lexeme();
                    add_gap();
                end
                text_q.push_back(8'd0);
            end else if (!cap_done && sent > 500) begin
                // A thousand one-character tokens, just short of the token limit, then ordinary text.
                cap_done = 1'b1;
                calm     = 1'b1;
                repeat (1000) begin
                    case ($urandom_range(0, 3))
                        0:       text_q.push_back(";");
                        1:       text_q.push_back(8'($urandom_range(128, 255)));
                        2:       add_str("+");
                        default: add_str("\"");
                    endcase
                end
                repeat (80) begin
                    add_lexeme();
                    add_gap();
                end
                text_q.push_back(8'd0);
            end else if (r < 12) begin
                repeat ($urandom_range(1, 24)) text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 25)) begin
                    add_lexeme();
                    add_gap();
                end
                text_q.push_back(8'd0);
            end
            send_text();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (tokens_due_cnt != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && tokens_due_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
